[rtl/bnpgl_pkg.sv]
// shared types, sizes and helpers for the banded nearest-point gain lookup
// no dependencies; used by bnpgl_ctrl, bnpgl_dp and the top level
package bnpgl_pkg;

  localparam int NUM_PATHS       = 4;
  localparam int NUM_BANDS       = 8;
  localparam int POINTS_PER_BAND = 16;

  localparam int SLOTS      = NUM_PATHS * NUM_BANDS;
  localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int BIDX_W     = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
  localparam int CNT_W      = $clog2(POINTS_PER_BAND + 1);
  localparam int PT_DEPTH   = SLOTS * POINTS_PER_BAND;
  localparam int PT_ADDR_W  = (PT_DEPTH > 1) ? $clog2(PT_DEPTH) : 1;

  localparam int MODE_W     = 2;
  localparam int PATH_W     = 2;
  localparam int BAND_W     = 3;
  localparam int FREQ_W     = 32;
  localparam int GAIN_W     = 16;
  localparam int IN_TDATA_W  = 120;
  localparam int OUT_TDATA_W = 48;

  typedef enum logic [MODE_W-1:0] {
    MODE_BAND  = 2'd0,
    MODE_POINT = 2'd1,
    MODE_QUERY = 2'd2
  } mode_t;

  typedef struct packed {
    logic latch;
    logic wr_band;
    logic append;
    logic band_rd;
    logic band_next;
    logic band_hit;
    logic band_miss;
    logic pt_rd;
    logic pt_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  path_ok;
    logic  band_match;
    logic  band_last;
    logic  has_table;
    logic  cnt_zero;
    logic  pt_stop;
    logic  pt_last;
    logic  pt_in_range;
    logic  out_free;
  } stat_t;

  function automatic logic [SLOT_W-1:0] slot_of(input logic [PATH_W-1:0] path,
                                                input logic [BIDX_W-1:0] bidx);
    return SLOT_W'(32'(path) * NUM_BANDS + 32'(bidx));
  endfunction

  function automatic logic [PT_ADDR_W-1:0] pt_addr(input logic [SLOT_W-1:0] slot,
                                                   input logic [CNT_W-1:0] idx);
    return PT_ADDR_W'(32'(slot) * POINTS_PER_BAND + 32'(idx));
  endfunction

endpackage

[rtl/bnpgl_ctrl.sv]
// sequencer for item decode, band scan, point walk and result hand-off
// depends on bnpgl_pkg (cmd_t, stat_t, mode_t)
module bnpgl_ctrl import bnpgl_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  s_axis_tvalid,
  output logic  s_axis_tready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_BAND_RD,
    ST_BAND_CMP,
    ST_PT_RD,
    ST_PT_CMP,
    ST_RESULT
  } state_t;

  state_t state, state_next;

  assign s_axis_tready = (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          cmd.latch  = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (stat.mode)
          MODE_BAND: begin
            cmd.wr_band = 1'b1;
            state_next  = ST_IDLE;
          end
          MODE_POINT: begin
            cmd.append = 1'b1;
            state_next = ST_IDLE;
          end
          MODE_QUERY: begin
            if (stat.path_ok) begin
              cmd.band_rd = 1'b1;
              state_next  = ST_BAND_CMP;
            end else begin
              cmd.band_miss = 1'b1;
              state_next    = ST_RESULT;
            end
          end
          default: state_next = ST_IDLE;
        endcase
      end
      ST_BAND_RD: begin
        cmd.band_rd = 1'b1;
        state_next  = ST_BAND_CMP;
      end
      ST_BAND_CMP: begin
        if (stat.band_match) begin
          cmd.band_hit = 1'b1;
          if (stat.has_table && !stat.cnt_zero) begin
            cmd.pt_rd  = 1'b1;
            state_next = ST_PT_CMP;
          end else begin
            state_next = ST_RESULT;
          end
        end else if (stat.band_last) begin
          cmd.band_miss = 1'b1;
          state_next    = ST_RESULT;
        end else begin
          cmd.band_next = 1'b1;
          state_next    = ST_BAND_RD;
        end
      end
      ST_PT_RD: begin
        cmd.pt_rd  = 1'b1;
        state_next = ST_PT_CMP;
      end
      ST_PT_CMP: begin
        cmd.pt_step = 1'b1;
        if (stat.pt_stop || stat.pt_last) begin
          state_next = ST_RESULT;
        end else begin
          state_next = ST_PT_RD;
        end
      end
      ST_RESULT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[rtl/bnpgl_dp.sv]
// datapath: item registers, band and point stores, compare logic, output register
// depends on bnpgl_pkg (sizes, cmd_t, stat_t, slot_of, pt_addr)
module bnpgl_dp import bnpgl_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic [MODE_W-1:0]      s_axis_tuser,
  input  cmd_t                   cmd,
  output stat_t                  stat,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic [0:0]             m_axis_tuser
);

  logic [MODE_W-1:0]        mode_q;
  logic [PATH_W-1:0]        path_q;
  logic [BAND_W-1:0]        band_q;
  logic                     tab_q;
  logic signed [FREQ_W-1:0] low_q;
  logic signed [FREQ_W-1:0] high_q;
  logic signed [FREQ_W-1:0] freq_q;
  logic signed [GAIN_W-1:0] gin_q;

  logic [BIDX_W-1:0] bidx;
  logic [CNT_W-1:0]  pidx;

  logic signed [FREQ_W-1:0] blow  [SLOTS];
  logic signed [FREQ_W-1:0] bhigh [SLOTS];
  logic                     bvalid [SLOTS];
  logic                     btab   [SLOTS];
  logic [CNT_W-1:0]         bcnt   [SLOTS];

  logic signed [FREQ_W-1:0] pmem_f [PT_DEPTH];
  logic signed [GAIN_W-1:0] pmem_g [PT_DEPTH];

  logic signed [FREQ_W-1:0] rd_low;
  logic signed [FREQ_W-1:0] rd_high;
  logic                     rd_valid;
  logic                     rd_tab;
  logic [CNT_W-1:0]         rd_cnt;
  logic signed [FREQ_W-1:0] rd_pf;
  logic signed [GAIN_W-1:0] rd_pg;

  logic                     res_found;
  logic signed [FREQ_W-1:0] res_freq;
  logic signed [GAIN_W-1:0] res_gain;

  logic                     m_found;
  logic signed [FREQ_W-1:0] m_freq;
  logic signed [GAIN_W-1:0] m_gain;

  logic [SLOT_W-1:0]        wr_slot;
  logic [SLOT_W-1:0]        cur_slot;
  logic                     path_ok;
  logic                     wr_ok;
  logic                     take_cur;
  logic signed [FREQ_W:0]   dprev;
  logic signed [FREQ_W:0]   dcur;
  logic [CNT_W-1:0]         pidx_inc;

  assign path_ok  = (32'(path_q) < NUM_PATHS);
  assign wr_ok    = path_ok && (32'(band_q) < NUM_BANDS);
  assign wr_slot  = slot_of(path_q, BIDX_W'(band_q));
  assign cur_slot = slot_of(path_q, bidx);
  assign pidx_inc = pidx + CNT_W'(1);

  // 33-bit distances to the previous and the current point
  assign dprev    = {freq_q[FREQ_W-1], freq_q} - {res_freq[FREQ_W-1], res_freq};
  assign dcur     = {rd_pf[FREQ_W-1], rd_pf} - {freq_q[FREQ_W-1], freq_q};
  assign take_cur = (pidx == '0) || (dprev > dcur);

  always_comb begin
    stat             = '0;
    stat.mode        = mode_t'(mode_q);
    stat.path_ok     = path_ok;
    stat.band_match  = rd_valid && (freq_q >= rd_low) && (freq_q <= rd_high);
    stat.band_last   = (32'(bidx) == NUM_BANDS - 1);
    stat.has_table   = rd_tab;
    stat.cnt_zero    = (rd_cnt == '0);
    stat.pt_stop     = (rd_pf >= freq_q);
    stat.pt_last     = (pidx_inc == rd_cnt);
    stat.pt_in_range = (pidx < rd_cnt);
    stat.out_free    = !m_axis_tvalid || m_axis_tready;
  end

  // item capture and scan counters
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      mode_q <= s_axis_tuser;
      path_q <= s_axis_tdata[1:0];
      band_q <= s_axis_tdata[4:2];
      tab_q  <= s_axis_tdata[5];
      low_q  <= s_axis_tdata[37:6];
      high_q <= s_axis_tdata[69:38];
      freq_q <= s_axis_tdata[101:70];
      gin_q  <= s_axis_tdata[117:102];
      bidx   <= '0;
      pidx   <= '0;
    end else begin
      if (cmd.band_next) begin
        bidx <= bidx + BIDX_W'(1);
      end
      if (cmd.pt_step && !stat.pt_stop) begin
        pidx <= pidx_inc;
      end
    end
  end

  // band flags and point counts, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        bvalid[i] <= 1'b0;
        btab[i]   <= 1'b0;
        bcnt[i]   <= '0;
      end
    end else if (cmd.wr_band && wr_ok) begin
      bvalid[wr_slot] <= 1'b1;
      btab[wr_slot]   <= tab_q;
      bcnt[wr_slot]   <= '0;
    end else if (cmd.append && wr_ok && (32'(bcnt[wr_slot]) < POINTS_PER_BAND)) begin
      bcnt[wr_slot] <= bcnt[wr_slot] + CNT_W'(1);
    end
  end

  // band limit store
  always_ff @(posedge clk) begin
    if (cmd.wr_band && wr_ok) begin
      blow[wr_slot]  <= low_q;
      bhigh[wr_slot] <= high_q;
    end
    if (cmd.band_rd) begin
      rd_low   <= blow[cur_slot];
      rd_high  <= bhigh[cur_slot];
      rd_valid <= bvalid[cur_slot];
      rd_tab   <= btab[cur_slot];
      rd_cnt   <= bcnt[cur_slot];
    end
  end

  // point store
  always_ff @(posedge clk) begin
    if (cmd.append && wr_ok && (32'(bcnt[wr_slot]) < POINTS_PER_BAND)) begin
      pmem_f[pt_addr(wr_slot, bcnt[wr_slot])] <= freq_q;
      pmem_g[pt_addr(wr_slot, bcnt[wr_slot])] <= gin_q;
    end
    if (cmd.pt_rd) begin
      rd_pf <= pmem_f[pt_addr(cur_slot, pidx)];
      rd_pg <= pmem_g[pt_addr(cur_slot, pidx)];
    end
  end

  // result under construction; res_freq and res_gain hold the previous point
  always_ff @(posedge clk) begin
    if (cmd.band_miss) begin
      res_found <= 1'b0;
      res_freq  <= '0;
      res_gain  <= '0;
    end else if (cmd.band_hit) begin
      res_found <= rd_tab;
      res_freq  <= '0;
      res_gain  <= '0;
    end else if (cmd.pt_step) begin
      if (!stat.pt_stop || take_cur) begin
        res_freq <= rd_pf;
        res_gain <= rd_pg;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_found <= res_found;
      m_freq  <= res_freq;
      m_gain  <= res_gain;
    end
  end

  assign m_axis_tdata = {m_freq, m_gain};
  assign m_axis_tuser = m_found;

endmodule

[rtl/banded_nearest_point_gain_lookup.sv]
// top level of the per-path banded nearest-point gain lookup
// depends on bnpgl_pkg, bnpgl_ctrl and bnpgl_dp
//
// channel  dir  tdata (low bit up)                                        tuser
// s_axis   in   path, band, band_has_table, lower_limit, upper_limit,    mode
//               freq, gain_in, 2 zero bits
// m_axis   out  gain, chosen_freq                                         found
//
// band write, point append and unused mode: executed in ST_EXEC, then ST_IDLE
// query: ST_EXEC, then ST_BAND_CMP and ST_BAND_RD in turn per band scanned, then
// ST_PT_CMP and ST_PT_RD in turn per point walked, then ST_RESULT; the band and
// point stores each give registered reads, one per compare state
// reset clears band valid flags and point counts at once; no clearing pass
// a result held by m_axis_tready low stalls only the next query's hand-off
module banded_nearest_point_gain_lookup import bnpgl_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // path, band, band_has_table, lower_limit,
                                                // upper_limit, freq, gain_in
  input  logic [MODE_W-1:0]      s_axis_tuser,  // mode
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // gain, chosen_freq
  output logic [0:0]             m_axis_tuser   // found
);

  cmd_t  cmd;
  stat_t stat;

  bnpgl_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .stat          (stat),
    .cmd           (cmd)
  );

  bnpgl_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cmd           (cmd),
    .stat          (stat),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> stat.out_free)
    else $error("result loaded over an untaken result");

  a_query_blocks: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && (s_axis_tuser == MODE_QUERY)) |=> !s_axis_tready)
    else $error("new item taken while a query is in flight");

  a_walk_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.pt_rd |-> stat.pt_in_range)
    else $error("point read beyond the band's count");

endmodule
